[rtl/bwr_pkg.sv]
package bwr_pkg;

  localparam int MaxTexW = 256;
  localparam int MaxTexH = 256;

  localparam int TexColW = $clog2(MaxTexW);
  localparam int TexRowW = $clog2(MaxTexH);
  localparam int CoordW = (TexColW > TexRowW) ? TexColW : TexRowW;

  localparam int BankColW = TexColW - 1;
  localparam int BankRowW = TexRowW - 1;
  localparam int BankAddrW = BankRowW + BankColW;
  localparam int BankDepth = 2 ** BankAddrW;
  localparam int NumBanks = 4;

  localparam int OriginW = 18;
  localparam int StepW = 24;
  localparam int SizeW = 9;
  localparam int IndexW = 10;
  localparam int TexelW = 8;
  localparam int LoadW = 8;
  localparam int PixelW = 16;
  localparam int WeightW = 8;

  // position with 17 fraction bits
  localparam int ProdW = IndexW + 1 + StepW;
  localparam int PosW = ProdW + 2;
  localparam int FracLsb = 17;
  localparam int IpW = PosW - FracLsb;
  localparam int HalfTexelQ17 = 65536;

  localparam int NumStages = 6;

  localparam int DataW = 32;
  localparam int PaddrW = 5;
  localparam int RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegWinLeft = 3'd0;
  localparam logic [RegIdxW-1:0] RegWinTop = 3'd1;
  localparam logic [RegIdxW-1:0] RegStepX = 3'd2;
  localparam logic [RegIdxW-1:0] RegStepY = 3'd3;
  localparam logic [RegIdxW-1:0] RegTexW = 3'd4;
  localparam logic [RegIdxW-1:0] RegTexH = 3'd5;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncSample = 1'b1;

  typedef struct packed {
    logic signed [OriginW-1:0] win_left;
    logic signed [OriginW-1:0] win_top;
    logic [StepW-1:0] step_x;
    logic [StepW-1:0] step_y;
    logic [CoordW-1:0] x_hi;
    logic [CoordW-1:0] y_hi;
  } cfg_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
    logic ld6;
  } pipe_en_t;

  typedef struct packed {
    logic we;
    logic [TexColW-1:0] col;
    logic [TexRowW-1:0] row;
    logic [TexelW-1:0] data;
  } tex_wr_t;

endpackage

[rtl/bwr_if.sv]
interface bwr_req_if;
  logic valid;
  logic ready;
  logic func;
  logic [bwr_pkg::LoadW-1:0] load_col;
  logic [bwr_pkg::LoadW-1:0] load_row;
  logic [bwr_pkg::TexelW-1:0] texel;
  logic [bwr_pkg::IndexW-1:0] out_col;
  logic [bwr_pkg::IndexW-1:0] out_row;

  modport source (
    output valid, func, load_col, load_row, texel, out_col, out_row,
    input ready
  );
  modport sink (
    input valid, func, load_col, load_row, texel, out_col, out_row,
    output ready
  );
endinterface

interface bwr_pix_if;
  logic valid;
  logic ready;
  logic [bwr_pkg::PixelW-1:0] pixel_value;

  modport source (output valid, pixel_value, input ready);
  modport sink (input valid, pixel_value, output ready);
endinterface

[rtl/bilinear_window_resample.sv]
// throughput: one transaction per cycle while the output is not stalled, set by the
// six-stage pipeline and the four-bank texture store that reads all four neighbours
// in the same cycle
// a stalled result holds only the unbroken run of full stages behind it
// reset clears the valid bits and the configuration registers to their defaults; the texture
// store is not cleared and must be written before it is sampled
module bilinear_window_resample (
  input  logic clk_i,
  input  logic rst_ni,
  bwr_req_if.sink req_i,
  bwr_pix_if.source pix_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [bwr_pkg::PaddrW-1:0] paddr,
  input  logic [bwr_pkg::DataW-1:0] pwdata,
  output logic [bwr_pkg::DataW-1:0] prdata,
  output logic pready
);

  localparam int NS = bwr_pkg::NumStages;
  localparam int CW = bwr_pkg::CoordW;
  localparam int XW = bwr_pkg::TexColW;
  localparam int YW = bwr_pkg::TexRowW;
  localparam int LW = bwr_pkg::LoadW;
  localparam int TW = bwr_pkg::TexelW;
  localparam int WW = bwr_pkg::WeightW;

  bwr_pkg::cfg_t cfg;
  bwr_pkg::pipe_en_t pen;
  bwr_pkg::tex_wr_t tex_wr;

  logic [NS-1:0] vld_q, vld_d, rdy;
  logic func1_q, func2_q, func3_q;
  logic [LW-1:0] lcol1_q, lcol2_q, lcol3_q;
  logic [LW-1:0] lrow1_q, lrow2_q, lrow3_q;
  logic [TW-1:0] texel1_q, texel2_q, texel3_q;
  logic [CW-1:0] x0, x1, y0, y1;
  logic [WW-1:0] wx, wy, wx4_q, wy4_q;
  logic [TW-1:0] ta, tb, tc, td;
  logic in_range;

  bwr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a stage takes new contents when it is empty or its successor moves
  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || pix_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    pen.ld1 = rdy[0];
    pen.ld2 = rdy[1];
    pen.ld3 = rdy[2];
    pen.ld4 = rdy[3];
    pen.ld5 = rdy[4];
    pen.ld6 = rdy[5];
  end

  // texel writes end when they commit to the store
  always_comb begin
    vld_d[0] = req_i.valid;
    vld_d[1] = vld_q[0];
    vld_d[2] = vld_q[1];
    vld_d[3] = vld_q[2] && (func3_q == bwr_pkg::FuncSample);
    vld_d[4] = vld_q[3];
    vld_d[5] = vld_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pen.ld1) begin
      func1_q <= req_i.func;
      lcol1_q <= req_i.load_col;
      lrow1_q <= req_i.load_row;
      texel1_q <= req_i.texel;
    end
    if (pen.ld2) begin
      func2_q <= func1_q;
      lcol2_q <= lcol1_q;
      lrow2_q <= lrow1_q;
      texel2_q <= texel1_q;
    end
    if (pen.ld3) begin
      func3_q <= func2_q;
      lcol3_q <= lcol2_q;
      lrow3_q <= lrow2_q;
      texel3_q <= texel2_q;
    end
    if (pen.ld4) begin
      wx4_q <= wx;
      wy4_q <= wy;
    end
  end

  assign req_i.ready = rdy[0];

  bwr_axis u_axis_x (
    .clk_i    (clk_i),
    .en_i     (pen),
    .origin_i (cfg.win_left),
    .step_i   (cfg.step_x),
    .index_i  (req_i.out_col),
    .hi_i     (cfg.x_hi),
    .n0_o     (x0),
    .n1_o     (x1),
    .wt_o     (wx)
  );

  bwr_axis u_axis_y (
    .clk_i    (clk_i),
    .en_i     (pen),
    .origin_i (cfg.win_top),
    .step_i   (cfg.step_y),
    .index_i  (req_i.out_row),
    .hi_i     (cfg.y_hi),
    .n0_o     (y0),
    .n1_o     (y1),
    .wt_o     (wy)
  );

  // writes outside the store are dropped
  assign in_range = (int'(lcol3_q) < bwr_pkg::MaxTexW) && (int'(lrow3_q) < bwr_pkg::MaxTexH);

  always_comb begin
    tex_wr.we = pen.ld4 && vld_q[2] && (func3_q == bwr_pkg::FuncWrite) && in_range;
    tex_wr.col = XW'(lcol3_q);
    tex_wr.row = YW'(lrow3_q);
    tex_wr.data = texel3_q;
  end

  bwr_tex_store u_store (
    .clk_i (clk_i),
    .wr_i  (tex_wr),
    .re_i  (pen.ld4),
    .x0_i  (XW'(x0)),
    .x1_i  (XW'(x1)),
    .y0_i  (YW'(y0)),
    .y1_i  (YW'(y1)),
    .a_o   (ta),
    .b_o   (tb),
    .c_o   (tc),
    .d_o   (td)
  );

  bwr_blend u_blend (
    .clk_i   (clk_i),
    .en_i    (pen),
    .a_i     (ta),
    .b_i     (tb),
    .c_i     (tc),
    .d_i     (td),
    .wx_i    (wx4_q),
    .wy_i    (wy4_q),
    .pixel_o (pix_o.pixel_value)
  );

  assign pix_o.valid = vld_q[NS-1];

`ifndef SYNTHESIS
  // the input only stalls when every stage is full and the result is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> ((&vld_q) && !pix_o.ready))
    else $error("input stalled with a free pipeline stage");

  // a committed texel write leaves a bubble behind, never a sample
  a_write_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tex_wr.we |=> !vld_q[3])
    else $error("texel write carried into the read stage");

  // a sample in the read stage moves on when the blend stage can take it
  a_read_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && rdy[4]) |=> vld_q[4])
    else $error("sample lost after the store read");
`endif

endmodule

[rtl/bwr_cfg.sv]
module bwr_cfg (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [bwr_pkg::PaddrW-1:0] paddr,
  input  logic [bwr_pkg::DataW-1:0] pwdata,
  output logic [bwr_pkg::DataW-1:0] prdata,
  output logic pready,
  output bwr_pkg::cfg_t cfg_o
);

  localparam int CW = bwr_pkg::CoordW;
  localparam int OW = bwr_pkg::OriginW;
  localparam int SW = bwr_pkg::StepW;
  localparam int ZW = bwr_pkg::SizeW;
  localparam int DW = bwr_pkg::DataW;

  logic [OW-1:0] win_left_q;
  logic [OW-1:0] win_top_q;
  logic [SW-1:0] step_x_q;
  logic [SW-1:0] step_y_q;
  logic [ZW-1:0] tex_w_q;
  logic [ZW-1:0] tex_h_q;
  logic [bwr_pkg::RegIdxW-1:0] idx;
  logic wr_en;

  // last texel index, with zero treated as one and large sizes saturated
  function automatic logic [CW-1:0] size_hi(input logic [ZW-1:0] raw, input int maxv);
    if (raw == '0) begin
      return '0;
    end else if (int'(raw) > maxv) begin
      return CW'(maxv - 1);
    end else begin
      return CW'(raw - ZW'(1));
    end
  endfunction

  assign idx = paddr[bwr_pkg::PaddrW-1:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q <= '0;
      win_top_q <= '0;
      step_x_q <= SW'(65536);
      step_y_q <= SW'(65536);
      tex_w_q <= ZW'(256);
      tex_h_q <= ZW'(256);
    end else if (wr_en) begin
      unique case (idx)
        bwr_pkg::RegWinLeft: win_left_q <= pwdata[OW-1:0];
        bwr_pkg::RegWinTop: win_top_q <= pwdata[OW-1:0];
        bwr_pkg::RegStepX: step_x_q <= pwdata[SW-1:0];
        bwr_pkg::RegStepY: step_y_q <= pwdata[SW-1:0];
        bwr_pkg::RegTexW: tex_w_q <= pwdata[ZW-1:0];
        bwr_pkg::RegTexH: tex_h_q <= pwdata[ZW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bwr_pkg::RegWinLeft: prdata = DW'(win_left_q);
      bwr_pkg::RegWinTop: prdata = DW'(win_top_q);
      bwr_pkg::RegStepX: prdata = DW'(step_x_q);
      bwr_pkg::RegStepY: prdata = DW'(step_y_q);
      bwr_pkg::RegTexW: prdata = DW'(tex_w_q);
      bwr_pkg::RegTexH: prdata = DW'(tex_h_q);
      default: prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.win_left = win_left_q;
    cfg_o.win_top = win_top_q;
    cfg_o.step_x = step_x_q;
    cfg_o.step_y = step_y_q;
    cfg_o.x_hi = size_hi(tex_w_q, bwr_pkg::MaxTexW);
    cfg_o.y_hi = size_hi(tex_h_q, bwr_pkg::MaxTexH);
  end

endmodule

[rtl/bwr_axis.sv]
module bwr_axis (
  input  logic clk_i,
  input  bwr_pkg::pipe_en_t en_i,
  input  logic signed [bwr_pkg::OriginW-1:0] origin_i,
  input  logic [bwr_pkg::StepW-1:0] step_i,
  input  logic [bwr_pkg::IndexW-1:0] index_i,
  input  logic [bwr_pkg::CoordW-1:0] hi_i,
  output logic [bwr_pkg::CoordW-1:0] n0_o,
  output logic [bwr_pkg::CoordW-1:0] n1_o,
  output logic [bwr_pkg::WeightW-1:0] wt_o
);

  localparam int CW = bwr_pkg::CoordW;
  localparam int PW = bwr_pkg::PosW;
  localparam int RW = bwr_pkg::ProdW;
  localparam int IW = bwr_pkg::IpW;
  localparam int FL = bwr_pkg::FracLsb;
  localparam int WW = bwr_pkg::WeightW;
  localparam logic signed [PW-1:0] HalfQ17 = PW'(bwr_pkg::HalfTexelQ17);

  logic [RW-1:0] prod_d, prod_q;
  logic signed [PW-1:0] pos_d, pos_q;
  logic signed [PW-1:0] org_ext;
  logic signed [IW-1:0] ip;
  logic signed [IW:0] ip1;
  logic [CW-1:0] n0_d, n0_q, n1_d, n1_q;
  logic [WW-1:0] wt_d, wt_q;

  function automatic logic [CW-1:0] clamp_hi(input logic signed [IW:0] v,
                                             input logic [CW-1:0] hi);
    if (v < 0) begin
      return '0;
    end else if (v > $signed({{(IW + 1 - CW){1'b0}}, hi})) begin
      return hi;
    end else begin
      return v[CW-1:0];
    end
  endfunction

  // stage 1: (2 * index + 1) * step
  assign prod_d = RW'({index_i, 1'b1}) * RW'(step_i);

  // stage 2: origin * 512 + product - 0.5 texel, all in 17 fraction bits
  assign org_ext = PW'(origin_i);
  assign pos_d = (org_ext <<< 9) + $signed(PW'(prod_q)) - HalfQ17;

  // stage 3: floor, clamp both neighbours, 8-bit weight
  assign ip = pos_q[PW-1:FL];
  assign ip1 = {ip[IW-1], ip} + {{IW{1'b0}}, 1'b1};
  assign n0_d = clamp_hi({ip[IW-1], ip}, hi_i);
  assign n1_d = clamp_hi(ip1, hi_i);
  assign wt_d = pos_q[FL-1:FL-WW];

  always_ff @(posedge clk_i) begin
    if (en_i.ld1) begin
      prod_q <= prod_d;
    end
    if (en_i.ld2) begin
      pos_q <= pos_d;
    end
    if (en_i.ld3) begin
      n0_q <= n0_d;
      n1_q <= n1_d;
      wt_q <= wt_d;
    end
  end

  assign n0_o = n0_q;
  assign n1_o = n1_q;
  assign wt_o = wt_q;

endmodule

[rtl/bwr_tex_store.sv]
module bwr_tex_store (
  input  logic clk_i,
  input  bwr_pkg::tex_wr_t wr_i,
  input  logic re_i,
  input  logic [bwr_pkg::TexColW-1:0] x0_i,
  input  logic [bwr_pkg::TexColW-1:0] x1_i,
  input  logic [bwr_pkg::TexRowW-1:0] y0_i,
  input  logic [bwr_pkg::TexRowW-1:0] y1_i,
  output logic [bwr_pkg::TexelW-1:0] a_o,
  output logic [bwr_pkg::TexelW-1:0] b_o,
  output logic [bwr_pkg::TexelW-1:0] c_o,
  output logic [bwr_pkg::TexelW-1:0] d_o
);

  localparam int XW = bwr_pkg::TexColW;
  localparam int YW = bwr_pkg::TexRowW;
  localparam int AW = bwr_pkg::BankAddrW;
  localparam int NB = bwr_pkg::NumBanks;
  localparam int TW = bwr_pkg::TexelW;

  logic [1:0] wbank;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr [NB];
  logic [TW-1:0] rd_q [NB];
  logic x0p_q, x1p_q, y0p_q, y1p_q;

  // banks split by row parity (high bit) and column parity (low bit)
  assign wbank = {wr_i.row[0], wr_i.col[0]};
  assign waddr = {wr_i.row[YW-1:1], wr_i.col[XW-1:1]};

  for (genvar b = 0; b < NB; b++) begin : g_bank
    localparam logic Cp = 1'(b % 2);
    localparam logic Rp = 1'(b / 2);
    logic [TW-1:0] bank_mem [bwr_pkg::BankDepth];
    logic [XW-1:0] col_sel;
    logic [YW-1:0] row_sel;

    // each bank serves whichever neighbour has its parity
    assign col_sel = (x0_i[0] == Cp) ? x0_i : x1_i;
    assign row_sel = (y0_i[0] == Rp) ? y0_i : y1_i;
    assign raddr[b] = {row_sel[YW-1:1], col_sel[XW-1:1]};

    always_ff @(posedge clk_i) begin
      if (wr_i.we && (wbank == 2'(b))) begin
        bank_mem[waddr] <= wr_i.data;
      end
      if (re_i) begin
        rd_q[b] <= bank_mem[raddr[b]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      x0p_q <= x0_i[0];
      x1p_q <= x1_i[0];
      y0p_q <= y0_i[0];
      y1p_q <= y1_i[0];
    end
  end

  assign a_o = rd_q[{y0p_q, x0p_q}];
  assign b_o = rd_q[{y0p_q, x1p_q}];
  assign c_o = rd_q[{y1p_q, x0p_q}];
  assign d_o = rd_q[{y1p_q, x1p_q}];

endmodule

[rtl/bwr_blend.sv]
module bwr_blend (
  input  logic clk_i,
  input  bwr_pkg::pipe_en_t en_i,
  input  logic [bwr_pkg::TexelW-1:0] a_i,
  input  logic [bwr_pkg::TexelW-1:0] b_i,
  input  logic [bwr_pkg::TexelW-1:0] c_i,
  input  logic [bwr_pkg::TexelW-1:0] d_i,
  input  logic [bwr_pkg::WeightW-1:0] wx_i,
  input  logic [bwr_pkg::WeightW-1:0] wy_i,
  output logic [bwr_pkg::PixelW-1:0] pixel_o
);

  localparam int WW = bwr_pkg::WeightW;
  localparam int PX = bwr_pkg::PixelW;

  logic [WW:0] wxc, wyc;
  logic [PX:0] col0_sum, col1_sum;
  logic [PX-1:0] c1_q, c2_q;
  logic [WW-1:0] wy_q;
  logic [PX+WW:0] row_sum;
  logic [PX-1:0] pix_q;

  assign wxc = 9'd256 - {1'b0, wx_i};
  assign col0_sum = 17'(a_i) * 17'(wxc) + 17'(b_i) * 17'(wx_i);
  assign col1_sum = 17'(c_i) * 17'(wxc) + 17'(d_i) * 17'(wx_i);

  assign wyc = 9'd256 - {1'b0, wy_q};
  assign row_sum = 25'(c1_q) * 25'(wyc) + 25'(c2_q) * 25'(wy_q);

  always_ff @(posedge clk_i) begin
    if (en_i.ld5) begin
      c1_q <= col0_sum[PX-1:0];
      c2_q <= col1_sum[PX-1:0];
      wy_q <= wy_i;
    end
    if (en_i.ld6) begin
      pix_q <= row_sum[PX+WW-1:WW];
    end
  end

  assign pixel_o = pix_q;

endmodule

[dv/tb_bilinear_window_resample.sv]
`timescale 1ns / 100ps

module tb_bilinear_window_resample;
  import bwr_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 300;
  localparam int DrainSlack = 2 * NumStages + 4;
  localparam int IndexMax = (1 << IndexW) - 1;
  localparam int PhaseItems = 100;
  localparam int NumPhases = 12;

  // decoded but unmapped register slots
  localparam logic [RegIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [RegIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic func;
    logic [LoadW-1:0] load_col;
    logic [LoadW-1:0] load_row;
    logic [TexelW-1:0] texel;
    logic [IndexW-1:0] out_col;
    logic [IndexW-1:0] out_row;
  } req_item_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PaddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  bwr_req_if req_if ();
  bwr_pix_if pix_if ();

  bilinear_window_resample uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .pix_o   (pix_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  req_item_t pending_reqs[$];
  logic [PixelW-1:0] expected_pixels[$];
  req_item_t next_req;
  logic [PixelW-1:0] want_pixel;

  // texel image as the block should hold it, and what the stimulus has written so far
  logic [TexelW-1:0] tex_mem [MaxTexW*MaxTexH];
  bit tex_filled [MaxTexW*MaxTexH];

  logic signed [OriginW-1:0] cur_left = '0;
  logic signed [OriginW-1:0] cur_top = '0;
  logic [StepW-1:0] cur_step_x = 24'h010000;
  logic [StepW-1:0] cur_step_y = 24'h010000;
  logic [SizeW-1:0] cur_tex_w = 9'd256;
  logic [SizeW-1:0] cur_tex_h = 9'd256;

  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  int mismatch_count = 0;
  int gen_count = 0;
  int cycle_count = 0;
  bit req_accepted = 1'b0;
  bit rx_hold = 1'b0;
  event hold_ev;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int tex_addr(int x, int y);
    return y * MaxTexW + x;
  endfunction

  function automatic int size_used(logic [SizeW-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int clamp_tap(longint v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // neighbours and 8-bit weight along one axis; position kept with 17 fraction bits
  function automatic void axis_taps(input logic signed [OriginW-1:0] origin,
                                    input logic [StepW-1:0] step,
                                    input logic [IndexW-1:0] idx, input int size,
                                    output int n0, output int n1, output int wt);
    longint p17;
    longint pos;
    longint ip;
    p17 = longint'(origin) * 512 + (2 * longint'(idx) + 1) * longint'(step)
          - longint'(HalfTexelQ17);
    pos = p17 >>> 1;
    ip = pos >>> 16;
    wt = int'((pos >>> 8) & 255);
    n0 = clamp_tap(ip, size - 1);
    n1 = clamp_tap(ip + 1, size - 1);
  endfunction

  function automatic logic [PixelW-1:0] blend_pixel(logic [IndexW-1:0] oc,
                                                    logic [IndexW-1:0] orow);
    int x0, x1, y0, y1, wx, wy;
    int unsigned a, b, c, d, c1, c2, res;
    axis_taps(cur_left, cur_step_x, oc, size_used(cur_tex_w, MaxTexW), x0, x1, wx);
    axis_taps(cur_top, cur_step_y, orow, size_used(cur_tex_h, MaxTexH), y0, y1, wy);
    a = tex_mem[tex_addr(x0, y0)];
    b = tex_mem[tex_addr(x1, y0)];
    c = tex_mem[tex_addr(x0, y1)];
    d = tex_mem[tex_addr(x1, y1)];
    c1 = a * (256 - wx) + b * wx;
    c2 = c * (256 - wx) + d * wx;
    res = (c1 * (256 - wy) + c2 * wy) >> 8;
    return res[PixelW-1:0];
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- stimulus queue

  task automatic add_write(logic [LoadW-1:0] col, logic [LoadW-1:0] row,
                           logic [TexelW-1:0] val);
    req_item_t it;
    it.func = FuncWrite;
    it.load_col = col;
    it.load_row = row;
    it.texel = val;
    it.out_col = $urandom_range(IndexMax);
    it.out_row = $urandom_range(IndexMax);
    tex_filled[tex_addr(col, row)] = 1'b1;
    pending_reqs.push_back(it);
    gen_count++;
  endtask

  task automatic fill_texel(int x, int y);
    if (!tex_filled[tex_addr(x, y)]) add_write(x[LoadW-1:0], y[LoadW-1:0], $urandom_range(255));
  endtask

  // a sample is queued only behind writes of every texel it will touch
  task automatic add_sample(logic [IndexW-1:0] oc, logic [IndexW-1:0] orow);
    req_item_t it;
    int x0, x1, y0, y1, wx, wy;
    axis_taps(cur_left, cur_step_x, oc, size_used(cur_tex_w, MaxTexW), x0, x1, wx);
    axis_taps(cur_top, cur_step_y, orow, size_used(cur_tex_h, MaxTexH), y0, y1, wy);
    fill_texel(x0, y0);
    fill_texel(x1, y0);
    fill_texel(x0, y1);
    fill_texel(x1, y1);
    it.func = FuncSample;
    it.load_col = $urandom_range(255);
    it.load_row = $urandom_range(255);
    it.texel = $urandom_range(255);
    it.out_col = oc;
    it.out_row = orow;
    pending_reqs.push_back(it);
    gen_count++;
  endtask

  function automatic logic [IndexW-1:0] pick_index(logic [StepW-1:0] step, int size);
    longint span;
    if ($urandom_range(9) == 0) return $urandom_range(IndexMax);
    span = ((longint'(size) + 1) << 16) / ((step == 0) ? 1 : longint'(step));
    if (span > IndexMax) span = IndexMax;
    return $urandom_range(int'(span));
  endfunction

  task automatic add_random_item();
    int w, h;
    w = size_used(cur_tex_w, MaxTexW);
    h = size_used(cur_tex_h, MaxTexH);
    if ($urandom_range(99) < 30) begin
      if ($urandom_range(3) != 0) begin
        add_write($urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(255));
      end else begin
        add_write($urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
    end else begin
      add_sample(pick_index(cur_step_x, w), pick_index(cur_step_y, h));
    end
  endtask

  // ---------------------------------------------------------------- config port

  task automatic apb_write(logic [RegIdxW-1:0] idx, logic [DataW-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegWinLeft: cur_left = data[OriginW-1:0];
      RegWinTop:  cur_top = data[OriginW-1:0];
      RegStepX:   cur_step_x = data[StepW-1:0];
      RegStepY:   cur_step_y = data[StepW-1:0];
      RegTexW:    cur_tex_w = data[SizeW-1:0];
      RegTexH:    cur_tex_h = data[SizeW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // junk in the unused upper bits of the data word
  function automatic logic [DataW-1:0] noisy_word(logic [DataW-1:0] v, int width);
    logic [DataW-1:0] m;
    m = (width >= DataW) ? '1 : ((DataW'(1) << width) - 1);
    return (v & m) | ($urandom() & ~m);
  endfunction

  task automatic set_window(logic signed [OriginW-1:0] ox, logic signed [OriginW-1:0] oy,
                            logic [StepW-1:0] sx, logic [StepW-1:0] sy,
                            logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    apb_write(RegWinLeft, noisy_word(ox, OriginW));
    apb_write(RegWinTop, noisy_word(oy, OriginW));
    apb_write(RegStepX, noisy_word(sx, StepW));
    apb_write(RegStepY, noisy_word(sy, StepW));
    apb_write(RegTexW, noisy_word(w, SizeW));
    apb_write(RegTexH, noisy_word(h, SizeW));
    apb_write($urandom_range(1) ? RegSpareHi : RegSpareLo, $urandom());
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(16, 1);
    if (r < 85) return $urandom_range(256, 17);
    case ($urandom_range(3))
      0: return 0;
      1: return 1;
      2: return 256;
      default: return $urandom_range(511, 257);
    endcase
  endfunction

  function automatic logic [StepW-1:0] pick_step();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(262144, 8192);
    if (r < 85) return $urandom_range(8191);
    return $urandom_range(24'hFFFFFF);
  endfunction

  function automatic logic [OriginW-1:0] pick_origin(int size);
    int v;
    if ($urandom_range(4) == 0) return $urandom_range((1 << OriginW) - 1);
    v = $urandom_range((size + 4) * 256) - 512;
    return v[OriginW-1:0];
  endfunction

  task automatic pick_window();
    int w, h;
    w = pick_size();
    h = pick_size();
    set_window(pick_origin(size_used(w, MaxTexW)), pick_origin(size_used(h, MaxTexH)),
               pick_step(), pick_step(), w[SizeW-1:0], h[SizeW-1:0]);
  endtask

  task automatic set_idle(int send_pct, int stall_pct);
    send_idle_pct = send_pct;
    rx_stall_pct = stall_pct;
  endtask

  // sender stays quiet until all queued requests are sent and all pixels are back
  task automatic drain_block();
    while (pending_reqs.size() != 0 || req_if.valid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver side

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_accepted) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        req_if.valid <= 1'b1;
        req_if.func <= next_req.func;
        req_if.load_col <= next_req.load_col;
        req_if.load_row <= next_req.load_row;
        req_if.texel <= next_req.texel;
        req_if.out_col <= next_req.out_col;
        req_if.out_row <= next_req.out_row;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    pix_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always begin
    @(hold_ev);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    req_accepted = 1'b0;
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %h with no request pending", pix_if.pixel_value));
        end else begin
          want_pixel = expected_pixels.pop_front();
          if (pix_if.pixel_value !== want_pixel)
            report_mismatch($sformatf("pixel_value got %h want %h",
                                      pix_if.pixel_value, want_pixel));
        end
      end
      if (req_if.valid && req_if.ready) begin
        req_accepted = 1'b1;
        if (req_if.func == FuncWrite) begin
          tex_mem[tex_addr(req_if.load_col, req_if.load_row)] = req_if.texel;
        end else begin
          expected_pixels.push_back(blend_pixel(req_if.out_col, req_if.out_row));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.func = FuncWrite;
    req_if.load_col = '0;
    req_if.load_row = '0;
    req_if.texel = '0;
    req_if.out_col = '0;
    req_if.out_row = '0;
    pix_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: unit step, positions land on texel centers
    set_idle(0, 0);
    add_write(8'd0, 8'd0, 8'hFF);
    add_write(8'd1, 8'd0, 8'h00);
    add_write(8'd0, 8'd1, 8'h80);
    add_write(8'd1, 8'd1, 8'h01);
    add_write(8'd255, 8'd255, 8'hFF);
    add_sample(10'd0, 10'd0);
    add_sample(10'd1, 10'd1);
    add_sample(10'd255, 10'd255);
    add_sample(10'd1023, 10'd1023);
    add_sample(10'd1023, 10'd0);
    drain_block();

    // window far outside the image on both sides, extreme steps
    set_window(18'h20000, 18'h1FFFF, 24'h008000, 24'hFFFFFF, 9'd256, 9'd256);
    add_sample(10'd0, 10'd0);
    add_sample(10'd1023, 10'd1023);
    add_sample(10'd517, 10'd3);
    drain_block();

    // fractional origin and step, zero width and oversized height
    set_window(18'h00080, 18'h3FFC0, 24'h00C000, 24'h014000, 9'd0, 9'd300);
    add_sample(10'd0, 10'd0);
    add_sample(10'd3, 10'd7);
    add_sample(10'd200, 10'd180);
    drain_block();

    // zero step, width above the maximum, single row
    set_window(18'h00000, 18'h00100, 24'h000000, 24'h000000, 9'd511, 9'd1);
    add_sample(10'd5, 10'd9);
    add_sample(10'd1023, 10'd1023);
    drain_block();

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: set_idle(0, 0);
        1: set_idle(64, 0);
        2: set_idle(0, 64);
        default: set_idle(38, 38);
      endcase
      if (p == 0) begin
        set_window(18'h00000, 18'h00000, 24'h010000, 24'h010000, 9'd256, 9'd256);
      end else begin
        pick_window();
      end
      // long output stall with the sender pushing flat out
      if (p == 6) set_idle(0, 0);
      gen_count = 0;
      while (gen_count < PhaseItems / 2) add_random_item();
      if (p == 6) -> hold_ev;
      if (p % 3 == 1) drain_block();
      while (gen_count < PhaseItems) add_random_item();
      drain_block();
    end

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bwr_pkg.sv
rtl/bwr_if.sv
rtl/bwr_cfg.sv
rtl/bwr_axis.sv
rtl/bwr_tex_store.sv
rtl/bwr_blend.sv
rtl/bilinear_window_resample.sv
dv/tb_bilinear_window_resample.sv
